### design/lprq_pkg.sv
// ----------------------------------------------------------------------------
// lprq_pkg: shared types and constants of the line packet receive queue
// Sizes of the packet ring, payload structs, request codes and the
// controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package lprq_pkg;

  localparam int QUEUE_SLOTS = 4;
  localparam int SLOT_BYTES  = 50;
  localparam int LINE_MAX    = SLOT_BYTES - 1;

  localparam int SLOT_W  = $clog2(QUEUE_SLOTS);
  localparam int LEN_W   = $clog2(SLOT_BYTES);
  localparam int ADDR_W  = $clog2(QUEUE_SLOTS * LINE_MAX);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int WAIT_W  = 2;

  localparam logic [7:0] LINE_END_RESET = 8'd10;

  // Request codes carried in req_type.
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } lprq_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              last_of_packet;
    logic              queue_empty;
    logic [WAIT_W-1:0] packets_waiting;
  } lprq_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FETCH,
    ST_REPLY
  } lprq_state_t;

  typedef struct packed {
    logic write_byte;
    logic start_deq;
    logic rd_issue;
    logic idx_inc;
    logic load_byte;
    logic load_empty;
  } lprq_cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic can_load;
    logic last_byte;
  } lprq_status_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    if (s == SLOT_W'(QUEUE_SLOTS - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  // Packets between tail and head, saturated to what packets_waiting can show.
  function automatic logic [WAIT_W-1:0] waiting_count(input logic [SLOT_W-1:0] head,
                                                      input logic [SLOT_W-1:0] tail);
    logic [CNT_W-1:0] cnt;
    if (head >= tail) begin
      cnt = CNT_W'(head) - CNT_W'(tail);
    end else begin
      cnt = CNT_W'(head) + CNT_W'(QUEUE_SLOTS) - CNT_W'(tail);
    end
    if (cnt > CNT_W'(3)) begin
      return WAIT_W'(3);
    end
    return WAIT_W'(cnt);
  endfunction

endpackage

### design/line_packet_receive_queue.sv
// ----------------------------------------------------------------------------
// line_packet_receive_queue: line-framed receive packet queue
// Assembles received bytes into lines, queues finished lines as packets in
// a ring of slots and plays the oldest packet back byte by byte on request.
// ----------------------------------------------------------------------------
// A received byte (req_type 0) keeps the controller idle and the block takes
// another byte in the very next cycle; it gives no result. When the byte
// equals cfg line-end character (10 after reset) the line, that byte
// included, becomes a packet; with the ring full the oldest packet is
// dropped, and the ring holds at most QUEUE_SLOTS-1 packets. A line that
// reaches SLOT_BYTES-1 bytes without a line end starts over at its first
// byte. A dequeue (req_type 1) holds in_stall high from the cycle after its
// beat until its last result byte has been loaded into the output register:
// state ST_ISSUE issues the first read of the single-port packet memory,
// whose read data is registered, then ST_FETCH loads one byte a cycle while
// the output is not stalled; the empty reply is loaded from ST_REPLY. The
// output register lets the next request be accepted while the final byte
// still waits to be taken. No clearing pass runs after reset; the block is
// ready in the first cycle after rst_n rises. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module line_packet_receive_queue
  import lprq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  lprq_in_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output lprq_out_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // Commands from the controller and status back from the datapath.
  lprq_cmd_t    cmd;
  lprq_status_t status;

  lprq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_data.req_type),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lprq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### design/lprq_ctrl.sv
// ----------------------------------------------------------------------------
// lprq_ctrl: sequencing controller
// Accepts requests, and for a dequeue steps the packet memory reads and the
// loads of the output register.
// ----------------------------------------------------------------------------
module lprq_ctrl
  import lprq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         req_type,
  output logic         in_stall,
  input  lprq_status_t status,
  output lprq_cmd_t    cmd
);

  lprq_state_t state_r;
  lprq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (req_type == REQ_DEQUEUE) begin
            cmd.start_deq = 1'b1;
            state_nxt     = status.ring_empty ? ST_REPLY : ST_ISSUE;
          end else begin
            cmd.write_byte = 1'b1;
          end
        end
      end
      ST_REPLY: begin
        if (status.can_load) begin
          cmd.load_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_FETCH;
      end
      ST_FETCH: begin
        if (status.can_load) begin
          cmd.load_byte = 1'b1;
          if (status.last_byte) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.rd_issue = 1'b1;
            cmd.idx_inc  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### design/lprq_dp.sv
// ----------------------------------------------------------------------------
// lprq_dp: packet ring datapath
// Packet memory, line write pointer, ring head and tail, packet lengths,
// the line-end register and the output register.
// ----------------------------------------------------------------------------
module lprq_dp
  import lprq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lprq_in_t     in_data,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  input  lprq_cmd_t    cmd,
  output lprq_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output lprq_out_t    out_data
);

  logic [7:0]        mem [QUEUE_SLOTS*LINE_MAX];
  logic [LEN_W-1:0]  len_mem [QUEUE_SLOTS];

  logic [7:0]        line_end_r;
  logic [LEN_W-1:0]  wp_r;
  logic [SLOT_W-1:0] head_r;
  logic [SLOT_W-1:0] tail_r;

  logic [ADDR_W-1:0] base_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  idx_r;
  logic [WAIT_W-1:0] left_r;
  logic [7:0]        rd_data_r;
  logic              out_valid_r;
  lprq_out_t         out_data_r;

  logic [LEN_W-1:0]  wp_inc;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [LEN_W-1:0]  rd_idx;
  logic              is_end;
  logic [SLOT_W-1:0] head_next;
  logic [SLOT_W-1:0] tail_next;

  always_comb begin
    wp_inc    = wp_r + 1'b1;
    wr_addr   = ADDR_W'(head_r) * ADDR_W'(LINE_MAX) + ADDR_W'(wp_r);
    rd_idx    = cmd.idx_inc ? idx_r + 1'b1 : idx_r;
    rd_addr   = base_r + ADDR_W'(rd_idx);
    is_end    = in_data.rx_byte == line_end_r;
    head_next = next_slot(head_r);
    tail_next = next_slot(tail_r);

    status.ring_empty = head_r == tail_r;
    status.can_load   = !out_valid_r || !out_stall;
    status.last_byte  = (idx_r + 1'b1) == len_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      mem[wr_addr] <= in_data.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Ring pointers and the configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_end_r <= LINE_END_RESET;
      wp_r       <= '0;
      head_r     <= '0;
      tail_r     <= '0;
    end else begin
      if (cfg_we) begin
        line_end_r <= cfg_wdata;
      end
      if (cmd.write_byte) begin
        if (is_end) begin
          wp_r   <= '0;
          head_r <= head_next;
          if (head_next == tail_r) begin
            tail_r <= tail_next;
          end
        end else if (wp_inc == LEN_W'(LINE_MAX)) begin
          wp_r <= '0;
        end else begin
          wp_r <= wp_inc;
        end
      end else if (cmd.start_deq && !status.ring_empty) begin
        tail_r <= tail_next;
      end
    end
  end

  // Packet length table and dequeue context.
  always_ff @(posedge clk) begin
    if (cmd.write_byte && is_end) begin
      len_mem[head_r] <= wp_inc;
    end
    if (cmd.start_deq) begin
      base_r <= ADDR_W'(tail_r) * ADDR_W'(LINE_MAX);
      len_r  <= len_mem[tail_r];
      left_r <= waiting_count(head_r, tail_next);
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_byte || cmd.load_empty) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      out_data_r.out_byte        <= rd_data_r;
      out_data_r.last_of_packet  <= status.last_byte;
      out_data_r.queue_empty     <= 1'b0;
      out_data_r.packets_waiting <= left_r;
    end else if (cmd.load_empty) begin
      out_data_r.out_byte        <= '0;
      out_data_r.last_of_packet  <= 1'b1;
      out_data_r.queue_empty     <= 1'b1;
      out_data_r.packets_waiting <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/lprq_checker.sv
// ----------------------------------------------------------------------------
// lprq_checker: port-level checks of the line packet receive queue
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lprq_checker
  import lprq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input lprq_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input lprq_out_t out_data
);

  // A stalled result beat stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The empty reply is a single, fully defined beat.
  a_empty_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.queue_empty |->
      out_data.last_of_packet && out_data.packets_waiting == '0 && out_data.out_byte == '0)
    else $error("malformed empty reply");

  // A dequeue beat makes the block busy in the next cycle.
  a_deq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == REQ_DEQUEUE |=> in_stall)
    else $error("input taken right after a dequeue");

  // No result is offered in the first cycle after reset is released.
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind line_packet_receive_queue lprq_checker u_lprq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/tb_line_packet_receive_queue.sv
// ----------------------------------------------------------------------------
// tb_line_packet_receive_queue: self-checking bench for the line packet queue
// Feeds received bytes and dequeue requests through the input channel while
// the output side stalls at random. A behavioral copy of the packet ring
// predicts every result beat. A short table of corner cases runs first, then
// random lines, noise and dequeues under several line-end characters.
// ----------------------------------------------------------------------------
module tb_line_packet_receive_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import lprq_pkg::*;

  // A run sends about 450 input beats with random gaps between bursts. Even if
  // every beat owed a full 49-byte packet and every result beat sat behind
  // the longest solid stall, it would still end far below CYCLE_LIMIT, which
  // leaves a wide margin on top.
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PHASE_BEATS   = 60;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 20;
  localparam int DIR_ROWS      = 16;

  // One row of stimulus. A row can repeat its beat, and where the result is
  // obvious it carries that result typed in, which then replaces whatever the
  // packet ring copy would say.
  typedef struct packed {
    lprq_in_t  item;
    logic [5:0] reps;
    logic      has_fixed;
    lprq_out_t fixed;
  } beat_t;

  localparam lprq_out_t EMPTY_REPLY = '{out_byte: 8'h00, last_of_packet: 1'b1,
                                        queue_empty: 1'b1, packets_waiting: '0};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lprq_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lprq_out_t out_data;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  line_packet_receive_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Behavioral copy of the packet ring. It is advanced once per accepted
  // input beat, in acceptance order, so it tracks the block exactly.
  // --------------------------------------------------------------------------
  logic [7:0] line_bytes [QUEUE_SLOTS*LINE_MAX];
  int         slot_len [QUEUE_SLOTS];
  int         fill_pos    = 0;
  int         newest_slot = 0;
  int         oldest_slot = 0;
  logic [7:0] cur_line_end = LINE_END_RESET;

  // Result beats that are owed by the block, oldest first.
  lprq_out_t  owed_results[$];

  int         mismatches = 0;
  int         cycle_cnt  = 0;
  int         burst_left = 0;
  int         stall_kind = 0;
  int         stall_left = 0;

  beat_t      dir_tbl [DIR_ROWS];

  // Works out the result beats of one request and updates the ring copy.
  function automatic void predict_beat(input lprq_in_t req, output lprq_out_t replies[$]);
    int slot;
    int len;
    int left;
    int nxt;
    lprq_out_t r;
    replies.delete();
    if (req.req_type == REQ_BYTE) begin
      // A line that has filled its slot without a line end starts over.
      if (fill_pos >= LINE_MAX) begin
        fill_pos = 0;
      end
      line_bytes[newest_slot*LINE_MAX + fill_pos] = req.rx_byte;
      fill_pos++;
      if (req.rx_byte == cur_line_end) begin
        nxt = (newest_slot + 1) % QUEUE_SLOTS;
        slot_len[newest_slot] = fill_pos;
        // A commit into a full ring drops the oldest packet.
        if (nxt == oldest_slot) begin
          oldest_slot = (oldest_slot + 1) % QUEUE_SLOTS;
        end
        newest_slot = nxt;
        fill_pos = 0;
      end
      if (fill_pos >= LINE_MAX) begin
        fill_pos = 0;
      end
    end else if (newest_slot == oldest_slot) begin
      replies.push_back(EMPTY_REPLY);
    end else begin
      slot = oldest_slot;
      len = slot_len[slot];
      oldest_slot = (oldest_slot + 1) % QUEUE_SLOTS;
      // The count shown is what is left once this packet has been taken.
      left = (newest_slot + QUEUE_SLOTS - oldest_slot) % QUEUE_SLOTS;
      if (left > 3) begin
        left = 3;
      end
      for (int i = 0; i < len; i++) begin
        r.out_byte        = line_bytes[slot*LINE_MAX + i];
        r.last_of_packet  = (i == len - 1);
        r.queue_empty     = 1'b0;
        r.packets_waiting = WAIT_W'(left);
        replies.push_back(r);
      end
    end
  endfunction

  function automatic void flag_mismatch(input string what, input lprq_out_t want,
                                        input lprq_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $write("%0t: %s: want byte %02h last %0b empty %0b waiting %0d, ",
             $realtime, what, want.out_byte, want.last_of_packet, want.queue_empty,
             want.packets_waiting);
      $display("got byte %02h last %0b empty %0b waiting %0d",
               got.out_byte, got.last_of_packet, got.queue_empty, got.packets_waiting);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. One beat is offered until it is taken; its expected results
  // are queued at the edge that takes it. The sender runs in bursts of
  // random length and idles for a random gap between them. in_valid stays
  // high across a burst, so it is never lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic drive_item(input beat_t b);
    lprq_out_t replies[$];
    int gap;
    in_valid <= 1'b1;
    in_data  <= b.item;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predict_beat(b.item, replies);
    if (b.has_fixed) begin
      owed_results.push_back(b.fixed);
    end else begin
      foreach (replies[i]) begin
        owed_results.push_back(replies[i]);
      end
    end
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stops sending and waits until every owed result beat has been taken.
  // At least one edge passes, so a following beat never raises in_valid in
  // the step that lowered it.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (owed_results.size() != 0);
  endtask

  // The line-end register is only written with the block idle. Received
  // bytes give no result, so a few spare cycles follow the drain before the
  // write goes out.
  task automatic set_line_end(input logic [7:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_line_end = value;
  endtask

  // Random traffic: mostly whole lines of random content ended by the
  // current line-end character, with dequeues mixed in and some loose bytes
  // as noise. Line lengths favor short packets; a few reach the slot limit
  // or run past it and wrap.
  task automatic run_random(input int beat_count);
    int sent;
    int kind;
    int len;
    logic [7:0] content;
    beat_t b;
    sent = 0;
    while (sent < beat_count) begin
      kind   = $urandom_range(0, 99);
      b      = '0;
      b.reps = 6'd1;
      if (kind < 35) begin
        b.item.req_type = REQ_DEQUEUE;
        b.item.rx_byte  = 8'($urandom_range(0, 255));
        drive_item(b);
        sent++;
      end else if (kind < 45) begin
        b.item.req_type = REQ_BYTE;
        b.item.rx_byte  = ($urandom_range(0, 3) == 0) ? cur_line_end
                                                      : 8'($urandom_range(0, 255));
        drive_item(b);
        sent++;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          len = $urandom_range(0, 8);
        end else if (kind < 95) begin
          len = $urandom_range(9, 47);
        end else begin
          len = $urandom_range(48, 60);
        end
        b.item.req_type = REQ_BYTE;
        repeat (len) begin
          do begin
            content = 8'($urandom_range(0, 255));
          end while (content == cur_line_end);
          b.item.rx_byte = content;
          drive_item(b);
        end
        b.item.rx_byte = cur_line_end;
        drive_item(b);
        sent += len + 1;
      end
      // Now and then the sender waits for the output side to catch up.
      if ($urandom_range(0, 49) == 0) begin
        hold_until_drained();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side. The receiver switches between runs of no stall, coin-flip
  // stalls and solid stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_left = (stall_kind == 2) ? $urandom_range(1, 15) : $urandom_range(4, 40);
      end else begin
        stall_left--;
      end
      case (stall_kind)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_stall <= 1'b1;
        end
      endcase
    end
  end

  // Every result beat taken is checked field by field against the oldest
  // owed one.
  always @(posedge clk) begin : result_check
    lprq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("result beat with nothing owed", '0, out_data);
      end else begin
        want = owed_results.pop_front();
        if (out_data.out_byte !== want.out_byte ||
            out_data.last_of_packet !== want.last_of_packet ||
            out_data.queue_empty !== want.queue_empty ||
            out_data.packets_waiting !== want.packets_waiting) begin
          flag_mismatch("result beat mismatch", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_line_packet_receive_queue: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (line_bytes[i]) begin
      line_bytes[i] = 8'h00;
    end
    foreach (slot_len[i]) begin
      slot_len[i] = 0;
    end

    // Corner cases with the line end at its reset value of 10.
    dir_tbl = '{
      // Dequeue straight after reset finds nothing.
      '{'{REQ_DEQUEUE, 8'h00}, 6'd1,  1'b1, EMPTY_REPLY},
      // A zero byte and an all-ones byte are plain data inside a line.
      '{'{REQ_BYTE,    8'h00}, 6'd1,  1'b0, '0},
      '{'{REQ_BYTE,    8'hFF}, 6'd1,  1'b0, '0},
      '{'{REQ_BYTE,    8'h0A}, 6'd1,  1'b0, '0},
      // A line of just the line end.
      '{'{REQ_BYTE,    8'h0A}, 6'd1,  1'b0, '0},
      // The longest line that fits a slot; this fills the ring.
      '{'{REQ_BYTE,    8'h41}, 6'd48, 1'b0, '0},
      '{'{REQ_BYTE,    8'h0A}, 6'd1,  1'b0, '0},
      // An overlong line wraps and starts over, then its commit drops the
      // oldest packet from the full ring.
      '{'{REQ_BYTE,    8'h55}, 6'd49, 1'b0, '0},
      '{'{REQ_BYTE,    8'h0A}, 6'd1,  1'b0, '0},
      // Drain all three packets, then one more dequeue finds nothing.
      '{'{REQ_DEQUEUE, 8'hFF}, 6'd3,  1'b0, '0},
      '{'{REQ_DEQUEUE, 8'h00}, 6'd1,  1'b1, EMPTY_REPLY},
      // A line in progress is not a packet yet.
      '{'{REQ_BYTE,    8'h80}, 6'd1,  1'b0, '0},
      '{'{REQ_BYTE,    8'h7F}, 6'd1,  1'b0, '0},
      '{'{REQ_DEQUEUE, 8'h5A}, 6'd1,  1'b1, EMPTY_REPLY},
      '{'{REQ_BYTE,    8'h0A}, 6'd1,  1'b0, '0},
      '{'{REQ_DEQUEUE, 8'hA5}, 6'd1,  1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[r]) begin
      repeat (dir_tbl[r].reps) drive_item(dir_tbl[r]);
    end
    run_random(PHASE_BEATS);

    // The line end at both extremes, at a random value, then back at 10.
    set_line_end(8'h00);
    run_random(PHASE_BEATS);
    set_line_end(8'hFF);
    run_random(PHASE_BEATS);
    set_line_end(8'($urandom_range(1, 254)));
    run_random(PHASE_BEATS);
    set_line_end(LINE_END_RESET);
    run_random(PHASE_BEATS);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_line_packet_receive_queue: done, clean");
    end else begin
      $display("tb_line_packet_receive_queue: done, errors");
    end
    $finish;
  end

endmodule
